// File: design/frame_pacing_deadline_monitor_assert.svh
// Assertion macros for the frame pacing deadline monitor.
// They expect clk_i and rst_ni in the scope of use.
`ifndef FRAME_PACING_DEADLINE_MONITOR_ASSERT_SVH
`define FRAME_PACING_DEADLINE_MONITOR_ASSERT_SVH

// Same-cycle implication.
`define FPDM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FPDM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/fpdm_pkg.sv
`timescale 1ns / 1ps

package fpdm_pkg;

  localparam int unsigned TICK_WIDTH_DEF = 32;
  localparam int unsigned TICK_IN_W      = 32;
  localparam int unsigned BYTE_W         = 32;
  localparam int unsigned FSIZE_W        = 24;
  localparam int unsigned TARGET_W       = 10;
  localparam int unsigned LIMIT_W        = 8;
  localparam int unsigned RATE_W         = 20;
  localparam int unsigned COUNT_W        = 8;
  localparam int unsigned QUO_W          = 20;
  localparam int unsigned QCNT_W         = $clog2(QUO_W);
  localparam int unsigned CFG_IDX_W      = 1;
  localparam int unsigned CFG_DATA_W     = 10;

  localparam logic [QUO_W-1:0]    RATE_SCALE   = QUO_W'(1000000);
  localparam logic [QUO_W-1:0]    MS_PER_SEC   = QUO_W'(1000);
  localparam logic [COUNT_W-1:0]  COUNT_MAX    = COUNT_W'(255);
  localparam logic [TARGET_W-1:0] TARGET_RESET = TARGET_W'(30);
  localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = LIMIT_W'(10);

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_RATE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MISS_LIMIT  = 1'b1;

endpackage

// File: design/frame_pacing_deadline_monitor.sv
`timescale 1ns / 1ps

// Frame pacing deadline monitor. Each input transaction is one timing check and
// produces exactly one result transaction. A check that does not complete a frame
// passes through S_EVAL and then S_FIN, which waits for a free output register.
// A check that completes a frame runs a shared bit-serial restoring divider twice,
// one quotient bit per cycle: first for the frame interval (1000 / target rate)
// and, when the tick difference is nonzero, for the rate (1000000 / difference).
// The block holds one check at a time; the next one is accepted while a finished
// result is still waiting in the output register.

module frame_pacing_deadline_monitor
  import fpdm_pkg::*;
#(
  parameter int unsigned TICK_WIDTH = TICK_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [TICK_IN_W-1:0]  tick_now_i,
  input  logic [BYTE_W-1:0]     bytes_read_i,
  input  logic [FSIZE_W-1:0]    frame_size_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  status_o,
  output logic                  frame_started_o,
  output logic [RATE_W-1:0]     frame_rate_o,
  output logic [COUNT_W-1:0]    missed_count_o
);

  localparam int unsigned TW = TICK_WIDTH;
  localparam int unsigned CW = (TW > QUO_W + 1) ? TW : QUO_W + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DIVI,
    S_DIVR,
    S_FIN
  } state_e;

  state_e state_q, state_d;

  logic [TARGET_W-1:0] target_q, target_d;
  logic [LIMIT_W-1:0]  limit_q, limit_d;
  logic [TW-1:0]       last_q, last_d;
  logic [TW-1:0]       deadline_q, deadline_d;
  logic [BYTE_W-1:0]   next_start_q, next_start_d;
  logic [RATE_W-1:0]   rate_q, rate_d;
  logic [COUNT_W-1:0]  miss_cnt_q, miss_cnt_d;

  logic [TW-1:0]       tick_q, tick_d;
  logic [BYTE_W-1:0]   bytes_q, bytes_d;
  logic [FSIZE_W-1:0]  fsize_q, fsize_d;
  logic [TW-1:0]       eff_q, eff_d;
  logic [TW-1:0]       diff_q, diff_d;
  logic                started_q, started_d;
  logic                missed_q, missed_d;

  logic [TW-1:0]       div_q, div_d;
  logic [QUO_W-1:0]    quo_q, quo_d;
  logic [QUO_W-1:0]    rem_q, rem_d;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;

  logic                out_valid_q, out_valid_d;
  logic                out_status_q, out_status_d;
  logic                out_started_q, out_started_d;
  logic [RATE_W-1:0]   out_rate_q, out_rate_d;
  logic [COUNT_W-1:0]  out_missed_q, out_missed_d;

  logic [TW-1:0]       eff_w;
  logic [QUO_W:0]      rem_sh;
  logic [CW-1:0]       rem_sub;
  logic                ge_w;
  logic [QUO_W-1:0]    rem_next;
  logic [QUO_W-1:0]    quo_next;
  logic                div_last;
  logic [TW-1:0]       ddl_w;
  logic [COUNT_W-1:0]  cnt_new;

  assign eff_w    = (tick_q < deadline_q) ? deadline_q : tick_q;
  assign rem_sh   = {rem_q, quo_q[QUO_W-1]};
  assign ge_w     = CW'(rem_sh) >= CW'(div_q);
  assign rem_sub  = CW'(rem_sh) - CW'(div_q);
  assign rem_next = ge_w ? QUO_W'(rem_sub) : QUO_W'(rem_sh);
  assign quo_next = {quo_q[QUO_W-2:0], ge_w};
  assign div_last = cnt_q == QCNT_W'(QUO_W - 1);
  assign ddl_w    = eff_q + TW'(quo_next);
  assign cnt_new  = (missed_q && (miss_cnt_q != COUNT_MAX)) ? miss_cnt_q + 1'b1 : miss_cnt_q;

  assign in_ready_o      = state_q == S_IDLE;
  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign frame_started_o = out_started_q;
  assign frame_rate_o    = out_rate_q;
  assign missed_count_o  = out_missed_q;

  always_comb begin
    state_d       = state_q;
    target_d      = target_q;
    limit_d       = limit_q;
    last_d        = last_q;
    deadline_d    = deadline_q;
    next_start_d  = next_start_q;
    rate_d        = rate_q;
    miss_cnt_d    = miss_cnt_q;
    tick_d        = tick_q;
    bytes_d       = bytes_q;
    fsize_d       = fsize_q;
    eff_d         = eff_q;
    diff_d        = diff_q;
    started_d     = started_q;
    missed_d      = missed_q;
    div_d         = div_q;
    quo_d         = quo_q;
    rem_d         = rem_q;
    cnt_d         = cnt_q;
    out_valid_d   = out_valid_q;
    out_status_d  = out_status_q;
    out_started_d = out_started_q;
    out_rate_d    = out_rate_q;
    out_missed_d  = out_missed_q;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TARGET_RATE: target_d = TARGET_W'(cfg_wdata_i);
        CFG_MISS_LIMIT:  limit_d  = cfg_wdata_i[LIMIT_W-1:0];
        default: ;
      endcase
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          tick_d  = TW'(tick_now_i);
          bytes_d = bytes_read_i;
          fsize_d = frame_size_i;
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (bytes_q >= next_start_q) begin
          started_d    = 1'b1;
          eff_d        = eff_w;
          diff_d       = eff_w - last_q;
          last_d       = eff_w;
          next_start_d = bytes_q + BYTE_W'(fsize_q);
          div_d        = (target_q == '0) ? TW'(1) : TW'(target_q);
          quo_d        = MS_PER_SEC;
          rem_d        = '0;
          cnt_d        = '0;
          state_d      = S_DIVI;
        end else begin
          started_d = 1'b0;
          missed_d  = tick_q >= deadline_q;
          state_d   = S_FIN;
        end
      end
      S_DIVI: begin
        quo_d = quo_next;
        rem_d = rem_next;
        cnt_d = cnt_q + 1'b1;
        if (div_last) begin
          deadline_d = ddl_w;
          missed_d   = eff_q >= ddl_w;
          if (diff_q != '0) begin
            div_d   = diff_q;
            quo_d   = RATE_SCALE;
            rem_d   = '0;
            cnt_d   = '0;
            state_d = S_DIVR;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_DIVR: begin
        quo_d = quo_next;
        rem_d = rem_next;
        cnt_d = cnt_q + 1'b1;
        if (div_last) begin
          rate_d  = RATE_W'(quo_next);
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          miss_cnt_d    = cnt_new;
          out_status_d  = missed_q && (cnt_new > COUNT_W'(limit_q));
          out_started_d = started_q;
          out_rate_d    = rate_q;
          out_missed_d  = cnt_new;
          out_valid_d   = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      target_q      <= TARGET_RESET;
      limit_q       <= LIMIT_RESET;
      last_q        <= '0;
      deadline_q    <= '0;
      next_start_q  <= '0;
      rate_q        <= '0;
      miss_cnt_q    <= '0;
      tick_q        <= '0;
      bytes_q       <= '0;
      fsize_q       <= '0;
      eff_q         <= '0;
      diff_q        <= '0;
      started_q     <= 1'b0;
      missed_q      <= 1'b0;
      div_q         <= '0;
      quo_q         <= '0;
      rem_q         <= '0;
      cnt_q         <= '0;
      out_valid_q   <= 1'b0;
      out_status_q  <= 1'b0;
      out_started_q <= 1'b0;
      out_rate_q    <= '0;
      out_missed_q  <= '0;
    end else begin
      state_q       <= state_d;
      target_q      <= target_d;
      limit_q       <= limit_d;
      last_q        <= last_d;
      deadline_q    <= deadline_d;
      next_start_q  <= next_start_d;
      rate_q        <= rate_d;
      miss_cnt_q    <= miss_cnt_d;
      tick_q        <= tick_d;
      bytes_q       <= bytes_d;
      fsize_q       <= fsize_d;
      eff_q         <= eff_d;
      diff_q        <= diff_d;
      started_q     <= started_d;
      missed_q      <= missed_d;
      div_q         <= div_d;
      quo_q         <= quo_d;
      rem_q         <= rem_d;
      cnt_q         <= cnt_d;
      out_valid_q   <= out_valid_d;
      out_status_q  <= out_status_d;
      out_started_q <= out_started_d;
      out_rate_q    <= out_rate_d;
      out_missed_q  <= out_missed_d;
    end
  end

`include "frame_pacing_deadline_monitor_assert.svh"

  `FPDM_ASSERT_NXT(a_accept_eval, in_valid_i && in_ready_o, state_q == S_EVAL, "accept did not start evaluation")
  `FPDM_ASSERT_IMP(a_div_count, state_q == S_DIVI || state_q == S_DIVR, cnt_q < QCNT_W'(QUO_W), "divider step count out of range")
  `FPDM_ASSERT_NXT(a_miss_mono, 1'b1, miss_cnt_q >= $past(miss_cnt_q), "miss counter decreased")
  `FPDM_ASSERT_IMP(a_status_lim, out_valid_q && out_status_q, out_missed_q > COUNT_W'(limit_q), "status set without exceeding limit")

endmodule
